### src/ipvr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the IRQ polling table
// and vector router. No dependencies; every other file imports this package.
package ipvr_pkg;

    localparam int POLL_SLOTS   = 12;
    localparam int VECTOR_COUNT = 256;
    localparam int SLOT_IDX_W   = (POLL_SLOTS > 1) ? $clog2(POLL_SLOTS) : 1;
    localparam int VEC_ADDR_W   = $clog2(VECTOR_COUNT);

    // Request kinds.
    localparam logic REQ_SETUP = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // Handler codes.
    localparam logic [2:0] H_TRAP     = 3'd0;
    localparam logic [2:0] H_SYSCALL  = 3'd1;
    localparam logic [2:0] H_TRACE    = 3'd2;
    localparam logic [2:0] H_TCALL    = 3'd3;
    localparam logic [2:0] H_TIMER    = 3'd4;
    localparam logic [2:0] H_IRQ      = 3'd5;
    localparam logic [2:0] H_RESERVED = 3'd6;

    // Error codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_PARAM = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    // Special vectors.
    localparam logic [7:0] TRACE_VEC   = 8'd9;
    localparam logic [7:0] AV_FIRST    = 8'd25;
    localparam logic [7:0] TIMER_VEC   = 8'd30;
    localparam logic [7:0] AV_LAST     = 8'd31;
    localparam logic [7:0] SYSCALL_VEC = 8'd32;
    localparam logic [7:0] TCALL_FIRST = 8'd33;
    localparam logic [7:0] TCALL_LAST  = 8'd47;

    // Number of vector table write steps after a slot update.
    localparam int          WSTEPS    = 7;
    localparam logic [2:0]  WSTEP_END = 3'(WSTEPS - 1);

    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
    typedef logic [VEC_ADDR_W-1:0] vec_addr_t;

    // Token that walks the cell chain and gathers the scan results.
    typedef struct packed {
        logic      valid;
        logic      match_found;
        slot_idx_t match_idx;
        logic      free_found;
        slot_idx_t free_idx;
        logic [1:0] vec_cnt;
        logic [1:0] occ_cnt;
    } scan_tok_t;

    // Broadcast write command to the slot cells.
    typedef struct packed {
        logic        en;
        logic        clear;
        slot_idx_t   idx;
        logic [7:0]  vec;
        logic [7:0]  prio;
        logic [31:0] isr;
        logic [31:0] st;
        logic [31:0] port;
    } slot_wr_t;

    // Write command to the vector table.
    typedef struct packed {
        logic       en;
        vec_addr_t  addr;
        logic [2:0] data;
    } vt_wr_t;

    // Handler code of a vector after reset.
    function automatic logic [2:0] default_handler(input vec_addr_t v);
        logic [7:0] v8;
        logic [2:0] h;
        v8 = 8'(v);
        if (v8 < 8'd2) begin
            h = H_RESERVED;
        end else if (v8 == TRACE_VEC) begin
            h = H_TRACE;
        end else if (v8 == TIMER_VEC) begin
            h = H_TIMER;
        end else if (v8 == SYSCALL_VEC) begin
            h = H_SYSCALL;
        end else if (v8 >= TCALL_FIRST && v8 <= TCALL_LAST) begin
            h = H_TCALL;
        end else begin
            h = H_TRAP;
        end
        return h;
    endfunction

    // Autovector addressed by write steps one through six: 25-29, then 31.
    function automatic logic [7:0] autovector(input logic [2:0] step);
        logic [7:0] a;
        if (step == WSTEP_END) begin
            a = AV_LAST;
        end else begin
            a = AV_FIRST + 8'(step) - 8'd1;
        end
        return a;
    endfunction

    // Saturating count up to two.
    function automatic logic [1:0] sat_inc(input logic [1:0] c, input logic b);
        logic [1:0] r;
        if (c == 2'd2) begin
            r = c;
        end else begin
            r = c + {1'b0, b};
        end
        return r;
    endfunction

endpackage

### src/irq_polling_table_vector_router_core.sv
`timescale 1ns / 1ps
// Top level of the IRQ polling table and vector router: sequencer, slot cell
// chain and vector table. Depends on ipvr_pkg, ipvr_cell and ipvr_vec_table.
//
// The block holds twelve polling slots (vector, priority, service routine,
// driver static address, port address) in a chain of cells, plus a 256-entry
// table of handler codes that comes out of reset at its built defaults. Each
// input transaction produces exactly one result transaction. A fetch reads
// the vector table through a registered read, forms its answer in the fetch
// state and then passes through the done state to the output register. A
// registration with a legal vector or a removal with a nonzero vector sends
// a scan token down the cell chain, one cell per cycle; the chosen slot is
// written as the token leaves the last cell, and then seven vector table
// write steps follow (the device vector and the autovectors 25-29 and 31),
// one table write port per cycle. A full table or a removal without a
// matching slot skips the write steps. A rejected request skips the scan
// and goes straight from idle to the done state. Items are handled one at a
// time; a finished result sits in the output register, so the next
// transaction is accepted while it still waits to be taken. The enable
// register is written through its own channel and should only be changed
// while the block is idle; with it cleared, slot updates still happen but
// the vector table is left untouched.
module irq_polling_table_vector_router_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Input transactions.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_vector_number,
    input  logic [7:0]  s_priority_req,
    input  logic [31:0] s_isr_address,
    input  logic [31:0] s_static_address,
    input  logic [31:0] s_port_address,
    // Result transactions.
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_success,
    output logic [1:0]  m_error_code,
    output logic [2:0]  m_handler_code,
    // Configuration write channel (vector_table_enabled).
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import ipvr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic        vte_reg;

    logic        req_type_reg;
    logic [7:0]  vec_reg;
    logic [7:0]  prio_reg;
    logic [31:0] isr_reg;
    logic [31:0] st_reg;
    logic [31:0] port_reg;

    logic        start_reg, start_next;
    logic [2:0]  wstep_reg, wstep_next;
    logic        do_vec_reg, do_vec_next;
    logic        do_auto_reg, do_auto_next;
    logic [2:0]  wcode_reg, wcode_next;

    logic        res_success_reg, res_success_next;
    logic [1:0]  res_err_reg, res_err_next;
    logic [2:0]  res_code_reg, res_code_next;

    logic        m_valid_reg, m_valid_next;
    logic        m_success_reg;
    logic [1:0]  m_err_reg;
    logic [2:0]  m_code_reg;

    logic        accept;
    logic        out_load;
    logic        in_vec_legal;
    logic        vec_in_range;
    logic        is_autovec;

    scan_tok_t   tok [POLL_SLOTS+1];
    scan_tok_t   tok_start;
    scan_tok_t   tok_last;
    slot_wr_t    slot_wr;
    vt_wr_t      vt_wr;
    logic [2:0]  vt_rd_data;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Vector range checks on the incoming transaction.
    assign vec_in_range = ({1'b0, s_vector_number} < 9'(VECTOR_COUNT));
    assign in_vec_legal = vec_in_range && (s_vector_number >= 8'd2)
                          && (s_vector_number != TIMER_VEC);
    assign is_autovec   = (vec_reg >= AV_FIRST) && (vec_reg <= AV_LAST);

    // The slot cell chain. A token enters cell 0 in the cycle after a scanning
    // setup is accepted and leaves the last cell with the scan result.
    always_comb begin
        tok_start       = '0;
        tok_start.valid = start_reg;
    end

    assign tok[0] = tok_start;

    for (genvar gi = 0; gi < POLL_SLOTS; gi++) begin : g_cell
        ipvr_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_idx   (SLOT_IDX_W'(gi)),
            .req_vec    (vec_reg),
            .req_static (st_reg),
            .tok_in     (tok[gi]),
            .tok_out    (tok[gi+1]),
            .slot_wr    (slot_wr)
        );
    end

    assign tok_last = tok[POLL_SLOTS];

    ipvr_vec_table u_vec_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (vt_wr),
        .rd_addr (s_vector_number[VEC_ADDR_W-1:0]),
        .rd_data (vt_rd_data)
    );

    // Vector table writes: step zero is the device vector, steps one to six
    // the autovectors.
    always_comb begin
        vt_wr = '0;
        if (state_reg == ST_WRITE) begin
            vt_wr.data = wcode_reg;
            if (wstep_reg == 3'd0) begin
                vt_wr.en   = do_vec_reg;
                vt_wr.addr = vec_reg[VEC_ADDR_W-1:0];
            end else begin
                vt_wr.en   = do_auto_reg;
                vt_wr.addr = VEC_ADDR_W'(autovector(wstep_reg));
            end
        end
    end

    // Sequencer.
    always_comb begin
        state_next       = state_reg;
        start_next       = 1'b0;
        wstep_next       = wstep_reg;
        do_vec_next      = do_vec_reg;
        do_auto_next     = do_auto_reg;
        wcode_next       = wcode_reg;
        res_success_next = res_success_reg;
        res_err_next     = res_err_reg;
        res_code_next    = res_code_reg;

        slot_wr       = '0;
        slot_wr.idx   = tok_last.match_idx;
        slot_wr.vec   = vec_reg;
        slot_wr.prio  = prio_reg;
        slot_wr.isr   = isr_reg;
        slot_wr.st    = st_reg;
        slot_wr.port  = port_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_success_next = 1'b0;
                    res_err_next     = ERR_PARAM;
                    res_code_next    = H_TRAP;
                    if (s_req_type == REQ_FETCH) begin
                        state_next = vec_in_range ? ST_FETCH : ST_DONE;
                    end else if (s_isr_address != 32'd0) begin
                        if (in_vec_legal) begin
                            state_next = ST_SCAN;
                            start_next = 1'b1;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end else if (s_vector_number != 8'd0) begin
                        state_next = ST_SCAN;
                        start_next = 1'b1;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FETCH: begin
                res_success_next = 1'b1;
                res_err_next     = ERR_NONE;
                res_code_next    = vt_rd_data;
                state_next       = ST_DONE;
            end
            ST_SCAN: begin
                if (tok_last.valid) begin
                    wstep_next = 3'd0;
                    if (isr_reg != 32'd0) begin
                        // Registration: a matching slot wins over a free one.
                        wcode_next   = H_IRQ;
                        do_vec_next  = vte_reg;
                        do_auto_next = vte_reg;
                        if (tok_last.match_found || tok_last.free_found) begin
                            slot_wr.en       = 1'b1;
                            slot_wr.idx      = tok_last.match_found ?
                                               tok_last.match_idx : tok_last.free_idx;
                            res_success_next = 1'b1;
                            res_err_next     = ERR_NONE;
                            state_next       = ST_WRITE;
                        end else begin
                            res_err_next = ERR_FULL;
                            state_next   = ST_DONE;
                        end
                    end else begin
                        // Removal: the vector goes back to trap when no other
                        // slot holds it; for an autovector, the autovectors
                        // follow when the table is then empty.
                        wcode_next   = H_TRAP;
                        do_vec_next  = vte_reg && (tok_last.vec_cnt < 2'd2);
                        do_auto_next = vte_reg && (tok_last.vec_cnt < 2'd2)
                                       && is_autovec && (tok_last.occ_cnt < 2'd2);
                        if (tok_last.match_found) begin
                            slot_wr.en       = 1'b1;
                            slot_wr.clear    = 1'b1;
                            res_success_next = 1'b1;
                            res_err_next     = ERR_NONE;
                            state_next       = ST_WRITE;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_WRITE: begin
                wstep_next = wstep_reg + 3'd1;
                if (wstep_reg == WSTEP_END) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            vte_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                vte_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_type_reg <= s_req_type;
            vec_reg      <= s_vector_number;
            prio_reg     <= s_priority_req;
            isr_reg      <= s_isr_address;
            st_reg       <= s_static_address;
            port_reg     <= s_port_address;
        end
        wstep_reg       <= wstep_next;
        do_vec_reg      <= do_vec_next;
        do_auto_reg     <= do_auto_next;
        wcode_reg       <= wcode_next;
        res_success_reg <= res_success_next;
        res_err_reg     <= res_err_next;
        res_code_reg    <= res_code_next;
        if (out_load) begin
            m_success_reg <= res_success_reg;
            m_err_reg     <= res_err_reg;
            m_code_reg    <= res_code_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_success      = m_success_reg;
    assign m_error_code   = m_err_reg;
    assign m_handler_code = m_code_reg;

`ifndef NO_ASSERTIONS
    // The vector table is only written during the write steps.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vt_wr.en |-> (state_reg == ST_WRITE))
        else $error("vector table written outside the write steps");

    // A scan token only leaves the chain while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tok_last.valid |-> (state_reg == ST_SCAN))
        else $error("scan token arrived outside a scan");

    // Slots are only changed when a scan has just finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        slot_wr.en |-> (tok_last.valid && (state_reg == ST_SCAN)))
        else $error("slot written without a finished scan");

    // A result reports success exactly when it carries no error.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_success == (m_error_code == ERR_NONE)))
        else $error("success flag disagrees with error code");

    // A handler code other than trap only comes from a successful fetch.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (res_code_reg != H_TRAP)) |-> (req_type_reg == REQ_FETCH))
        else $error("handler code on a non-fetch result");
`endif

endmodule

### src/ipvr_cell.sv
`timescale 1ns / 1ps
// One polling table slot and its stage of the scan chain.
// Depends on ipvr_pkg.
module ipvr_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ipvr_pkg::slot_idx_t   cell_idx,
    input  logic [7:0]            req_vec,
    input  logic [31:0]           req_static,
    input  ipvr_pkg::scan_tok_t   tok_in,
    output ipvr_pkg::scan_tok_t   tok_out,
    input  ipvr_pkg::slot_wr_t    slot_wr
);
    import ipvr_pkg::*;

    logic [7:0]  vec_reg;
    logic [7:0]  prio_reg;
    logic [31:0] isr_reg;
    logic [31:0] st_reg;
    logic [31:0] port_reg;
    scan_tok_t   tok_reg;
    scan_tok_t   tok_next;

    logic occupied;
    logic vec_hit;
    logic full_hit;
    logic wr_here;

    assign occupied = (vec_reg != 8'd0);
    assign vec_hit  = (vec_reg == req_vec);
    assign full_hit = occupied && vec_hit && (st_reg == req_static);
    assign wr_here  = slot_wr.en && (slot_wr.idx == cell_idx);

    always_comb begin
        tok_next             = tok_in;
        tok_next.match_found = tok_in.match_found | full_hit;
        tok_next.match_idx   = tok_in.match_found ? tok_in.match_idx : cell_idx;
        tok_next.free_found  = tok_in.free_found | !occupied;
        tok_next.free_idx    = tok_in.free_found ? tok_in.free_idx : cell_idx;
        tok_next.vec_cnt     = sat_inc(tok_in.vec_cnt, vec_hit);
        tok_next.occ_cnt     = sat_inc(tok_in.occ_cnt, occupied);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
            vec_reg <= 8'd0;
        end else begin
            tok_reg <= tok_next;
            if (wr_here) begin
                vec_reg <= slot_wr.clear ? 8'd0 : slot_wr.vec;
            end
        end
    end

    // Entry payload; only meaningful while the slot is occupied.
    always_ff @(posedge aclk) begin
        if (wr_here) begin
            prio_reg <= slot_wr.clear ? 8'd0  : slot_wr.prio;
            isr_reg  <= slot_wr.clear ? 32'd0 : slot_wr.isr;
            st_reg   <= slot_wr.clear ? 32'd0 : slot_wr.st;
            port_reg <= slot_wr.clear ? 32'd0 : slot_wr.port;
        end
    end

    assign tok_out = tok_reg;

endmodule

### src/ipvr_vec_table.sv
`timescale 1ns / 1ps
// Vector handler table: one write and one registered read per cycle, with a
// valid bit per entry so unwritten entries read as their built default.
// Depends on ipvr_pkg.
module ipvr_vec_table (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ipvr_pkg::vt_wr_t     wr,
    input  ipvr_pkg::vec_addr_t  rd_addr,
    output logic [2:0]           rd_data
);
    import ipvr_pkg::*;

    logic [2:0]              mem [VECTOR_COUNT];
    logic [VECTOR_COUNT-1:0] valid_reg;
    logic [2:0]              mem_rd_reg;
    logic                    valid_rd_reg;
    logic [2:0]              dflt_rd_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        mem_rd_reg  <= mem[rd_addr];
        dflt_rd_reg <= default_handler(rd_addr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            valid_rd_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = valid_rd_reg ? mem_rd_reg : dflt_rd_reg;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for irq_polling_table_vector_router_core.
// Depends on ipvr_pkg and the core; a scoreboard class predicts every answer.
module testbench;
    import ipvr_pkg::*;

    // Quiet cycles (nothing accepted on any channel) before the run is abandoned.
    // That leaves a wide margin over a registration, even with long receiver stalls.
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 150;
    localparam int PHASE_COUNT = 6;

    // A few driver static addresses are reused so that registrations often
    // hit an existing slot and removals often find their owner.
    localparam logic [31:0] OWNER_A = 32'h1234_5678;
    localparam logic [31:0] OWNER_B = 32'hA5A5_0000;
    localparam logic [31:0] OWNER_C = 32'h0000_0000;
    localparam logic [31:0] OWNER_D = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  vec;
        logic [7:0]  prio;
        logic [31:0] isr;
        logic [31:0] owner;
        logic [31:0] port;
    } request_t;

    typedef struct packed {
        logic       success;
        logic [1:0] err;
        logic [2:0] code;
    } answer_t;

    // The scoreboard keeps its own copy of the polling slots, the handler
    // table and the enable bit. Each accepted request is applied to that copy
    // and the answer it must produce is queued; each result taken from the
    // core is compared with the oldest queued answer.
    class vector_route_scoreboard;
        bit          routing_on;
        logic [7:0]  poll_vec   [POLL_SLOTS];
        logic [7:0]  poll_prio  [POLL_SLOTS];
        logic [31:0] poll_isr   [POLL_SLOTS];
        logic [31:0] poll_owner [POLL_SLOTS];
        logic [31:0] poll_port  [POLL_SLOTS];
        logic [2:0]  handler_of [VECTOR_COUNT];
        answer_t     expected_answers[$];
        int unsigned failures;

        function new();
            int v;
            routing_on = 1'b1;
            failures = 0;
            for (v = 0; v < POLL_SLOTS; v++) begin
                poll_vec[v] = '0;
                poll_prio[v] = '0;
                poll_isr[v] = '0;
                poll_owner[v] = '0;
                poll_port[v] = '0;
            end
            for (v = 0; v < VECTOR_COUNT; v++) begin
                handler_of[v] = (v < 2) ? H_RESERVED : H_TRAP;
            end
            handler_of[TRACE_VEC] = H_TRACE;
            handler_of[TIMER_VEC] = H_TIMER;
            handler_of[SYSCALL_VEC] = H_SYSCALL;
            for (v = TCALL_FIRST; v <= TCALL_LAST; v++) begin
                handler_of[v] = H_TCALL;
            end
        endfunction

        function void set_enable(bit on);
            routing_on = on;
        endfunction

        // Autovectors 25-29 and 31; the timer vector in between is left alone.
        function void route_autovectors(logic [2:0] code);
            int v;
            for (v = AV_FIRST; v <= AV_LAST; v++) begin
                if (v != TIMER_VEC) begin
                    handler_of[v] = code;
                end
            end
        endfunction

        function void log_request(request_t rq);
            answer_t ans;
            int      pick;
            int      i;
            bit      still_used;
            bit      table_empty;
            ans.success = 1'b0;
            ans.err = ERR_NONE;
            ans.code = H_TRAP;
            pick = -1;
            if (rq.req_type == REQ_FETCH) begin
                if (int'(rq.vec) < VECTOR_COUNT) begin
                    ans.code = handler_of[rq.vec];
                end else begin
                    ans.err = ERR_PARAM;
                end
            end else if (rq.isr == '0) begin
                // Removal: only an occupied slot with the same owner matches.
                if (rq.vec != 8'd0) begin
                    for (i = 0; i < POLL_SLOTS; i++) begin
                        if (poll_vec[i] == rq.vec && poll_owner[i] == rq.owner) begin
                            pick = i;
                            break;
                        end
                    end
                end
                if (pick < 0) begin
                    ans.err = ERR_PARAM;
                end else begin
                    poll_vec[pick] = '0;
                    poll_prio[pick] = '0;
                    poll_isr[pick] = '0;
                    poll_owner[pick] = '0;
                    poll_port[pick] = '0;
                    still_used = 1'b0;
                    table_empty = 1'b1;
                    for (i = 0; i < POLL_SLOTS; i++) begin
                        if (poll_vec[i] == rq.vec) begin
                            still_used = 1'b1;
                        end
                        if (poll_vec[i] != 8'd0) begin
                            table_empty = 1'b0;
                        end
                    end
                    // An unused vector falls back to trap, whatever its default
                    // was; for an autovector, an empty table also releases the autovectors.
                    if (!still_used && routing_on) begin
                        if (int'(rq.vec) < VECTOR_COUNT) begin
                            handler_of[rq.vec] = H_TRAP;
                        end
                        if (rq.vec >= AV_FIRST && rq.vec <= AV_LAST && table_empty) begin
                            route_autovectors(H_TRAP);
                        end
                    end
                end
            end else begin
                if (rq.vec < 8'd2 || int'(rq.vec) >= VECTOR_COUNT || rq.vec == TIMER_VEC) begin
                    ans.err = ERR_PARAM;
                end else begin
                    // A slot owned by the same driver for the same vector wins;
                    // otherwise the first free slot is taken.
                    for (i = 0; i < POLL_SLOTS; i++) begin
                        if (poll_vec[i] == 8'd0) begin
                            if (pick < 0) begin
                                pick = i;
                            end
                        end else if (poll_vec[i] == rq.vec && poll_owner[i] == rq.owner) begin
                            pick = i;
                            break;
                        end
                    end
                    if (pick < 0) begin
                        ans.err = ERR_FULL;
                    end else begin
                        poll_vec[pick] = rq.vec;
                        poll_prio[pick] = rq.prio;
                        poll_isr[pick] = rq.isr;
                        poll_owner[pick] = rq.owner;
                        poll_port[pick] = rq.port;
                        if (routing_on) begin
                            handler_of[rq.vec] = H_IRQ;
                            route_autovectors(H_IRQ);
                        end
                    end
                end
            end
            ans.success = (ans.err == ERR_NONE);
            expected_answers.push_back(ans);
        endfunction

        function void check_answer(logic success, logic [1:0] err, logic [2:0] code);
            answer_t want;
            if (expected_answers.size() == 0) begin
                $error("result with no request outstanding: success=%0d error_code=%0d handler_code=%0d",
                       success, err, code);
                failures++;
                return;
            end
            want = expected_answers.pop_front();
            if (success !== want.success) begin
                $error("success: expected %0d, actual %0d", want.success, success);
                failures++;
            end
            if (err !== want.err) begin
                $error("error_code: expected %0d, actual %0d", want.err, err);
                failures++;
            end
            if (code !== want.code) begin
                $error("handler_code: expected %0d, actual %0d", want.code, code);
                failures++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = 1'b0;
    logic [7:0]  s_vector_number = '0;
    logic [7:0]  s_priority_req = '0;
    logic [31:0] s_isr_address = '0;
    logic [31:0] s_static_address = '0;
    logic [31:0] s_port_address = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_success;
    logic [1:0]  m_error_code;
    logic [2:0]  m_handler_code;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          quiet_cycles = 0;

    vector_route_scoreboard route_sb;

    irq_polling_table_vector_router_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_vector_number  (s_vector_number),
        .s_priority_req   (s_priority_req),
        .s_isr_address    (s_isr_address),
        .s_static_address (s_static_address),
        .s_port_address   (s_port_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_success        (m_success),
        .m_error_code     (m_error_code),
        .m_handler_code   (m_handler_code),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result side: every result transaction is checked as it is taken, then
    // the ready for the next edge is drawn from the current stall rate. The
    // check reads m_ready before this block updates it, so it sees the value
    // that the core saw at the same edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            route_sb.check_answer(m_success, m_error_code, m_handler_code);
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: the run is abandoned after a long stretch with no transaction
    // on any of the three channels.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("irq_polling_table_vector_router_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic request_t setup_req(logic [7:0] vec, logic [7:0] prio, logic [31:0] isr,
                                           logic [31:0] owner, logic [31:0] port);
        request_t rq;
        rq.req_type = REQ_SETUP;
        rq.vec = vec;
        rq.prio = prio;
        rq.isr = isr;
        rq.owner = owner;
        rq.port = port;
        return rq;
    endfunction

    // The unused fields of a fetch carry random bits; the core must ignore them.
    function automatic request_t fetch_req(logic [7:0] vec);
        request_t rq;
        rq.req_type = REQ_FETCH;
        rq.vec = vec;
        rq.prio = 8'($urandom);
        rq.isr = $urandom;
        rq.owner = $urandom;
        rq.port = $urandom;
        return rq;
    endfunction

    // Vectors are drawn mostly from the low range, where the defaults,
    // autovectors and rejected numbers live, so the table fills and empties
    // around interesting entries.
    function automatic logic [7:0] pick_vector();
        logic [7:0] v;
        case ($urandom_range(9))
            0: begin
                v = ($urandom_range(2) == 0) ? TIMER_VEC : 8'($urandom_range(1));
            end
            1, 2: begin
                v = 8'($urandom_range(AV_LAST, AV_FIRST));
            end
            3, 4, 5, 6: begin
                v = 8'($urandom_range(TCALL_LAST, 2));
            end
            7: begin
                v = TRACE_VEC;
            end
            default: begin
                v = 8'($urandom_range(255));
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_owner();
        logic [31:0] o;
        case ($urandom_range(9))
            0, 1: o = OWNER_A;
            2, 3: o = OWNER_B;
            4:    o = OWNER_C;
            5:    o = OWNER_D;
            6:    o = OWNER_A ^ 32'h1;
            default: o = $urandom;
        endcase
        return o;
    endfunction

    // Random mix: fetches, registrations and removals with random content,
    // most removals aimed at a slot that is occupied right now, plus a share
    // of unstructured noise.
    function automatic request_t make_random_request();
        request_t rq;
        int       kind;
        int       slot;
        kind = $urandom_range(99);
        rq = setup_req(pick_vector(), 8'($urandom), $urandom, pick_owner(), $urandom);
        if (kind < 25) begin
            rq = fetch_req(pick_vector());
        end else if (kind < 30) begin
            rq.vec = 8'($urandom_range(255));
            rq.owner = $urandom;
            if ($urandom_range(1) == 0) begin
                rq.isr = '0;
            end
        end else if (kind < 63) begin
            if (rq.isr == '0) begin
                rq.isr = 32'h1;
            end
        end else begin
            rq.isr = '0;
            slot = $urandom_range(POLL_SLOTS - 1);
            if (route_sb.poll_vec[slot] != 8'd0 && $urandom_range(3) != 0) begin
                rq.vec = route_sb.poll_vec[slot];
                rq.owner = route_sb.poll_owner[slot];
            end
        end
        return rq;
    endfunction

    // Present one request and hold it until the core takes it. The valid is
    // left high afterward so that back-to-back requests follow without a gap;
    // a gap, if drawn, is what lowers it.
    task automatic send_request(request_t rq);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= rq.req_type;
        s_vector_number <= rq.vec;
        s_priority_req <= rq.prio;
        s_isr_address <= rq.isr;
        s_static_address <= rq.owner;
        s_port_address <= rq.port;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        route_sb.log_request(rq);
    endtask

    // Stop sending and wait until every queued answer has come back. The loop
    // always waits for a clock edge before it checks, so the valid is never lowered and
    // raised again within the same time step.
    task automatic drain_answers();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (route_sb.expected_answers.size() != 0);
    endtask

    task automatic write_enable(bit on);
        cfg_valid <= 1'b1;
        cfg_data <= on;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        route_sb.set_enable(on);
    endtask

    initial begin
        int p;
        int n;
        int v;
        route_sb = new();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 6;
        recv_idle_pct = 70;
        write_enable(1'b1);

        // Built defaults: reserved, trace and timer vectors.
        send_request(fetch_req(8'd0));
        send_request(fetch_req(TRACE_VEC));
        send_request(fetch_req(TIMER_VEC));
        // Registrations of vectors 0, 1 and the timer vector are rejected.
        send_request(setup_req(8'd0, 8'h11, 32'h0000_1000, OWNER_A, 32'h10));
        send_request(setup_req(8'd1, 8'h22, 32'h0000_2000, OWNER_A, 32'h20));
        send_request(setup_req(TIMER_VEC, 8'h33, 32'h0000_3000, OWNER_A, 32'h30));
        // Removal of vector 0, and a removal that finds no slot.
        send_request(setup_req(8'd0, 8'h00, 32'h0, OWNER_A, 32'h0));
        send_request(setup_req(8'd64, 8'h00, 32'h0, OWNER_B, 32'h0));
        // An autovector registration, then its removal from an otherwise empty
        // table, which must hand the autovectors back to trap.
        send_request(setup_req(8'd27, 8'h40, 32'h0000_4000, OWNER_A, 32'h40));
        send_request(fetch_req(8'd29));
        send_request(setup_req(8'd27, 8'h00, 32'h0, OWNER_A, 32'h0));
        send_request(fetch_req(8'd29));
        // All-ones fields, then a second registration by the same owner that
        // must land in the same slot.
        send_request(setup_req(8'd255, 8'hFF, 32'hFFFF_FFFF, OWNER_D, 32'hFFFF_FFFF));
        send_request(setup_req(8'd255, 8'h00, 32'h8000_0001, OWNER_D, 32'h0));
        send_request(fetch_req(8'd255));
        // Fill the remaining slots, overwriting the trace default on the way,
        // and overflow the table.
        for (v = 2; v <= 12; v++) begin
            send_request(setup_req(8'(v), 8'(v), 32'h100 + v, OWNER_B, 32'h200 + v));
        end
        send_request(setup_req(8'd13, 8'h13, 32'h0000_0113, OWNER_B, 32'h213));
        send_request(setup_req(8'd255, 8'h00, 32'h0, OWNER_D, 32'h0));
        send_request(fetch_req(8'd255));
        drain_answers();

        // Random phases: two per idling pattern, with the enable bit toggled
        // at each phase boundary while the core is idle.
        for (p = 0; p < PHASE_COUNT; p++) begin
            case (p / 2)
                0: begin
                    send_idle_pct = 6;
                    recv_idle_pct = 70;
                end
                1: begin
                    send_idle_pct = 70;
                    recv_idle_pct = 6;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_enable((p % 2) != 0);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Now and then the sender waits for every answer before going on.
                if ($urandom_range(59) == 0) begin
                    drain_answers();
                end
                send_request(make_random_request());
            end
            drain_answers();
        end

        // Give a stray late result time to show up before the verdict.
        repeat (32) @(posedge aclk);
        if (route_sb.failures == 0 && route_sb.expected_answers.size() == 0) begin
            $display("irq_polling_table_vector_router_core: match");
        end else begin
            $display("irq_polling_table_vector_router_core: mismatch");
        end
        $finish;
    end

endmodule
